// ===== rtl/mfsk_pkg.sv =====
// Shared types, constants and table-building functions for the MFSK tone generator.
// No dependencies; compiled first.
package mfsk_pkg;

   localparam int PHASE_BITS_DEF      = 32;
   localparam int SAMPLE_BITS_DEF     = 16;
   localparam int MAX_SPS_DEF         = 64;
   localparam int MAX_ORDER_LOG2_DEF  = 6;
   localparam int TABLE_ADDR_BITS_DEF = 10;

   localparam int SYMBOL_BITS    = 6;
   localparam int ORDER_BITS     = 3;
   localparam int SPS_BITS       = 7;
   localparam int FREQ_BITS      = 32;
   localparam int COUNT_BITS     = 32;
   localparam int COEF_BITS      = SYMBOL_BITS + 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORDER_LOG2 = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPS        = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREQ_STEP  = 2'd2;

   localparam logic [ORDER_BITS-1:0] ORDER_LOG2_RESET = 3'd1;
   localparam logic [SPS_BITS-1:0]   SPS_RESET        = 7'd8;
   localparam logic [FREQ_BITS-1:0]  FREQ_STEP_RESET  = 32'd268435456;

   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [ORDER_BITS-1:0] order_log2;
      logic [SPS_BITS-1:0]   samples_per_symbol;
      logic [FREQ_BITS-1:0]  freq_step;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic advance;
   } status_type;

   function automatic longint unsigned mulq(input longint unsigned a,
                                            input longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned one_minus(input longint unsigned v);
      return (v < Q30_ONE) ? (Q30_ONE - v) : 64'd0;
   endfunction

   function automatic longint unsigned sin_q30(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = mulq(x, x);
      t  = one_minus(x2 / 110);
      t  = one_minus(mulq(x2, t) / 72);
      t  = one_minus(mulq(x2, t) / 42);
      t  = one_minus(mulq(x2, t) / 20);
      t  = one_minus(mulq(x2, t) / 6);
      return mulq(x, t);
   endfunction

   function automatic longint unsigned cos_q30(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = mulq(x, x);
      t  = one_minus(x2 / 132);
      t  = one_minus(mulq(x2, t) / 90);
      t  = one_minus(mulq(x2, t) / 56);
      t  = one_minus(mulq(x2, t) / 30);
      t  = one_minus(mulq(x2, t) / 12);
      return one_minus(mulq(x2, t) / 2);
   endfunction

   function automatic longint unsigned scale_amp(input longint unsigned v,
                                                 input int sample_bits);
      longint unsigned amp;
      longint unsigned r;
      amp = (64'd1 << (sample_bits - 1)) - 64'd1;
      r   = (amp * v + (64'd1 << 29)) >> 30;
      return (r > amp) ? amp : r;
   endfunction

   // Quarter-wave magnitude for entry k; want_sin picks sine over cosine.
   function automatic longint unsigned tone_mag(input int k, input int quarter_bits,
                                                input int sample_bits, input bit want_sin);
      longint unsigned x;
      x = (longint'(k) * HALF_PI_Q30) >> quarter_bits;
      return want_sin ? scale_amp(sin_q30(x), sample_bits)
                      : scale_amp(cos_q30(x), sample_bits);
   endfunction

endpackage

// ===== rtl/mfsk_if.sv =====
// Request and response channel interfaces for the MFSK tone generator.
// Depends on mfsk_pkg.
interface mfsk_req_if;
   import mfsk_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SYMBOL_BITS-1:0] symbol_index;
   modport source (output valid, output symbol_index, input ready);
   modport sink (input valid, input symbol_index, output ready);
endinterface

interface mfsk_rsp_if #(
   parameter int SAMPLE_BITS = mfsk_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_phase;
   logic signed [SAMPLE_BITS-1:0] quadrature;
   logic                          last;
   modport source (output valid, output in_phase, output quadrature, output last,
                   input ready);
   modport sink (input valid, input in_phase, input quadrature, input last,
                 output ready);
endinterface

// ===== rtl/mfsk_tone_generator.sv =====
// MFSK tone generator top level: channels, register bank, sequencer and datapath.
// Depends on mfsk_pkg, mfsk_if, mfsk_csr, mfsk_ctrl and mfsk_dp.
//
// Usage:
//   req_ch carries one tone index per request; rsp_ch returns samples_per_symbol
//   complex samples (in_phase = cos, quadrature = sin) per request, with last set
//   on the final sample of each burst. csr_we/csr_index/csr_wdata write the
//   tone order, burst length and frequency step; write them only while idle.
// Timing:
//   The first sample of a burst passes the issue, phase multiply, table lookup and
//   output register stages after the request is accepted. Samples then leave at
//   one per clock while rsp_ch is ready, and the next request is taken in the
//   cycle of the last issue; bursts stream without gaps. The sample counter n
//   advances once per sample and never restarts between bursts; the phase n*f
//   comes from one 32x32 multiplier; samples_per_symbol is clamped to 1..MAX_SPS.
// Reset and stall:
//   Reset clears the counter, the pipeline and the sequencer and restores the
//   register defaults. While rsp_ch is valid and not ready the whole pipeline
//   holds and the sequencer issues no sample, so no sample is lost or repeated.
module mfsk_tone_generator #(
   parameter int PHASE_BITS      = mfsk_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_BITS     = mfsk_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_SPS         = mfsk_pkg::MAX_SPS_DEF,
   parameter int MAX_ORDER_LOG2  = mfsk_pkg::MAX_ORDER_LOG2_DEF,
   parameter int TABLE_ADDR_BITS = mfsk_pkg::TABLE_ADDR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mfsk_req_if.sink                            req_ch,
   mfsk_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [mfsk_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mfsk_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mfsk_pkg::*;

   cfg_type                       cfg;
   cmd_type                       cmd;
   status_type                    status;
   logic                          req_ready;
   logic                          rsp_valid;
   logic signed [SAMPLE_BITS-1:0] in_phase;
   logic signed [SAMPLE_BITS-1:0] quadrature;
   logic                          last;

   mfsk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mfsk_ctrl #(
      .MAX_SPS (MAX_SPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mfsk_dp #(
      .PHASE_BITS      (PHASE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .MAX_ORDER_LOG2  (MAX_ORDER_LOG2),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .symbol_index (req_ch.symbol_index),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ch.ready),
      .in_phase     (in_phase),
      .quadrature   (quadrature),
      .last         (last)
   );

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.in_phase   = in_phase;
   assign rsp_ch.quadrature = quadrature;
   assign rsp_ch.last       = last;

endmodule

// ===== rtl/mfsk_csr.sv =====
// Configuration register bank: tone order, burst length and frequency step.
// Depends on mfsk_pkg.
module mfsk_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mfsk_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mfsk_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output mfsk_pkg::cfg_type                    cfg
);
   import mfsk_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ORDER_LOG2: cfg_in.order_log2         = csr_wdata[ORDER_BITS-1:0];
            CSR_SPS:        cfg_in.samples_per_symbol = csr_wdata[SPS_BITS-1:0];
            CSR_FREQ_STEP:  cfg_in.freq_step          = csr_wdata[FREQ_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.order_log2         <= ORDER_LOG2_RESET;
         cfg_ff.samples_per_symbol <= SPS_RESET;
         cfg_ff.freq_step          <= FREQ_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/mfsk_ctrl.sv =====
// Burst sequencer: accepts a request and issues one sample per advancing cycle.
// Depends on mfsk_pkg.
module mfsk_ctrl #(
   parameter int MAX_SPS = mfsk_pkg::MAX_SPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mfsk_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mfsk_pkg::status_type status,
   output mfsk_pkg::cmd_type    cmd
);
   import mfsk_pkg::*;

   localparam int POS_BITS = $clog2(MAX_SPS);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_BURST = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [SPS_BITS-1:0]  sps_eff;
   logic [SPS_BITS-1:0]  sps_last;
   logic [POS_BITS-1:0]  last_pos;
   logic                 req_accept;

   always_comb begin
      if (cfg.samples_per_symbol == '0) begin
         sps_eff = SPS_BITS'(1);
      end else if (cfg.samples_per_symbol > SPS_BITS'(MAX_SPS)) begin
         sps_eff = SPS_BITS'(MAX_SPS);
      end else begin
         sps_eff = cfg.samples_per_symbol;
      end
   end

   assign sps_last = sps_eff - SPS_BITS'(1);
   assign last_pos = sps_last[POS_BITS-1:0];

   always_comb begin
      cmd.load  = 1'b0;
      cmd.issue = 1'b0;
      cmd.last  = 1'b0;
      req_ready = 1'b0;
      state_in  = state_ff;
      pos_in    = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_BURST;
               pos_in   = '0;
            end
         end
         ST_BURST: begin
            cmd.issue = status.advance;
            cmd.last  = status.advance && (pos_ff == last_pos);
            req_ready = cmd.last;
            if (cmd.last) begin
               pos_in   = '0;
               state_in = req_valid ? ST_BURST : ST_IDLE;
            end else if (cmd.issue) begin
               pos_in = pos_ff + POS_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
            pos_in   = '0;
         end
      endcase
      cmd.load = req_valid && req_ready;
   end

   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pos_in_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BURST) |-> (pos_ff <= last_pos))
      else $error("burst position beyond burst length");
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.last && !req_accept) |=> (state_ff == ST_IDLE))
      else $error("burst did not end after last sample");
`endif

endmodule

// ===== rtl/mfsk_dp.sv =====
// Datapath: frequency word, sample counter, phase multiply, quarter-wave ROM and
// output register with quadrant mapping. Depends on mfsk_pkg.
module mfsk_dp #(
   parameter int PHASE_BITS      = mfsk_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_BITS     = mfsk_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_ORDER_LOG2  = mfsk_pkg::MAX_ORDER_LOG2_DEF,
   parameter int TABLE_ADDR_BITS = mfsk_pkg::TABLE_ADDR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mfsk_pkg::cfg_type                   cfg,
   input  logic [mfsk_pkg::SYMBOL_BITS-1:0]    symbol_index,
   input  mfsk_pkg::cmd_type                   cmd,
   output mfsk_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       in_phase,
   output logic signed [SAMPLE_BITS-1:0]       quadrature,
   output logic                                last
);
   import mfsk_pkg::*;

   localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
   localparam int QUARTER      = 1 << QUARTER_BITS;
   localparam int MAG_BITS     = SAMPLE_BITS - 1;

   typedef logic [MAG_BITS-1:0] mag_type;
   typedef mag_type rom_type [QUARTER];

   function automatic rom_type build_rom(input bit want_sin);
      rom_type t;
      for (int k = 0; k < QUARTER; k++) begin
         t[k] = mag_type'(tone_mag(k, QUARTER_BITS, SAMPLE_BITS, want_sin));
      end
      return t;
   endfunction

   localparam rom_type COS_ROM = build_rom(1'b0);
   localparam rom_type SIN_ROM = build_rom(1'b1);

   // symbol to frequency word
   logic [ORDER_BITS-1:0]             lg_eff;
   logic [SYMBOL_BITS-1:0]            idx_max;
   logic [SYMBOL_BITS-1:0]            idx_sat;
   logic [COEF_BITS-1:0]              tone_count;
   logic [COEF_BITS-1:0]              odd_index;
   logic signed [COEF_BITS-1:0]       coef;
   logic signed [FREQ_BITS+COEF_BITS:0] fw_prod;
   logic [FREQ_BITS-1:0]              fw_ff;
   logic [COUNT_BITS-1:0]             counter_ff;
   logic [COUNT_BITS-1:0]             phase_full;
   logic                              advance;

   logic                              valid1_ff, last1_ff;
   logic [PHASE_BITS-1:0]             phase1_ff;
   logic [TABLE_ADDR_BITS-1:0]        addr1;

   logic                              valid2_ff, last2_ff;
   logic [1:0]                        quad2_ff;
   mag_type                           cos2_ff, sin2_ff;
   logic signed [SAMPLE_BITS-1:0]     cos_pos, cos_neg, sin_pos, sin_neg;

   logic                              valid3_ff, last3_ff;
   logic signed [SAMPLE_BITS-1:0]     in_phase_ff, in_phase_in;
   logic signed [SAMPLE_BITS-1:0]     quad_ff, quad_in;

   always_comb begin
      if (cfg.order_log2 == '0) begin
         lg_eff = ORDER_BITS'(1);
      end else if (cfg.order_log2 > ORDER_BITS'(MAX_ORDER_LOG2)) begin
         lg_eff = ORDER_BITS'(MAX_ORDER_LOG2);
      end else begin
         lg_eff = cfg.order_log2;
      end
   end

   assign idx_max    = ~({SYMBOL_BITS{1'b1}} << lg_eff);
   assign idx_sat    = (symbol_index > idx_max) ? idx_max : symbol_index;
   assign tone_count = COEF_BITS'(1) << lg_eff;
   assign odd_index  = {1'b0, idx_sat, 1'b1};
   assign coef       = $signed(odd_index - tone_count);
   assign fw_prod    = $signed({1'b0, cfg.freq_step}) * coef;

   assign advance        = !valid3_ff || rsp_ready;
   assign status.advance = advance;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fw_ff <= fw_prod[FREQ_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else if (cmd.issue) begin
         counter_ff <= counter_ff + COUNT_BITS'(1);
      end
   end

   // stage 1: phase = n * f mod 2^32
   assign phase_full = counter_ff * fw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last1_ff  <= cmd.last;
         phase1_ff <= phase_full[COUNT_BITS-1 -: PHASE_BITS];
      end
   end

   // stage 2: quarter-wave lookup
   assign addr1 = phase1_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (advance) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last2_ff <= last1_ff;
         quad2_ff <= addr1[TABLE_ADDR_BITS-1 -: 2];
         cos2_ff  <= COS_ROM[addr1[QUARTER_BITS-1:0]];
         sin2_ff  <= SIN_ROM[addr1[QUARTER_BITS-1:0]];
      end
   end

   // stage 3: quadrant mapping into the output register
   assign cos_pos = $signed({1'b0, cos2_ff});
   assign sin_pos = $signed({1'b0, sin2_ff});
   assign cos_neg = -cos_pos;
   assign sin_neg = -sin_pos;

   always_comb begin
      case (quad2_ff)
         2'd0: begin
            in_phase_in = cos_pos;
            quad_in     = sin_pos;
         end
         2'd1: begin
            in_phase_in = sin_neg;
            quad_in     = cos_pos;
         end
         2'd2: begin
            in_phase_in = cos_neg;
            quad_in     = sin_neg;
         end
         default: begin
            in_phase_in = sin_pos;
            quad_in     = cos_neg;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last3_ff    <= last2_ff;
         in_phase_ff <= in_phase_in;
         quad_ff     <= quad_in;
      end
   end

   assign rsp_valid  = valid3_ff;
   assign in_phase   = in_phase_ff;
   assign quadrature = quad_ff;
   assign last       = last3_ff;

`ifndef NO_ASSERTIONS
   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (counter_ff == $past(counter_ff) + COUNT_BITS'($past(cmd.issue))))
      else $error("sample counter out of step with issued samples");
   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      (advance && valid1_ff) |=> valid2_ff)
      else $error("sample lost between phase and lookup stages");
`endif

endmodule

// ===== tb/tb_mfsk_tone_generator.sv =====
// Self-checking testbench for mfsk_tone_generator: predicts every cos/sin sample of each
// symbol burst and checks the response stream under random sender gaps and receiver stalls.
// Depends on mfsk_pkg, mfsk_if and mfsk_tone_generator from rtl.
module tb_mfsk_tone_generator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_ORDER = 6;
   localparam int MAX_BURST = 64;
   localparam logic [mfsk_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam longint unsigned UNITY_Q30 = 64'd1 << 30;
   localparam longint unsigned HALF_PI = 64'd1686629713;
   localparam longint unsigned AMPLITUDE = 64'd32767;

   typedef struct packed {
      logic [15:0] in_phase;
      logic [15:0] quadrature;
      logic        last;
   } sample_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [mfsk_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [mfsk_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   mfsk_req_if req ();
   mfsk_rsp_if rsp ();

   mfsk_tone_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // tone generator model state
   logic [2:0]  tone_order = mfsk_pkg::ORDER_LOG2_RESET;
   logic [6:0]  burst_len  = mfsk_pkg::SPS_RESET;
   logic [31:0] tone_step  = mfsk_pkg::FREQ_STEP_RESET;
   logic [31:0] tone_counter = '0;

   sample_type samples_due[$];
   int failures = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned complement_q30(input longint unsigned v);
      return (v < UNITY_Q30) ? (UNITY_Q30 - v) : 64'd0;
   endfunction

   function automatic longint unsigned sine_poly(input longint unsigned x);
      longint unsigned x2;
      longint unsigned acc;
      x2  = qmul(x, x);
      acc = complement_q30(x2 / 110);
      acc = complement_q30(qmul(x2, acc) / 72);
      acc = complement_q30(qmul(x2, acc) / 42);
      acc = complement_q30(qmul(x2, acc) / 20);
      acc = complement_q30(qmul(x2, acc) / 6);
      return qmul(x, acc);
   endfunction

   function automatic longint unsigned cosine_poly(input longint unsigned x);
      longint unsigned x2;
      longint unsigned acc;
      x2  = qmul(x, x);
      acc = complement_q30(x2 / 132);
      acc = complement_q30(qmul(x2, acc) / 90);
      acc = complement_q30(qmul(x2, acc) / 56);
      acc = complement_q30(qmul(x2, acc) / 30);
      acc = complement_q30(qmul(x2, acc) / 12);
      return complement_q30(qmul(x2, acc) / 2);
   endfunction

   function automatic logic [15:0] amp_round(input longint unsigned v);
      longint unsigned r;
      r = (AMPLITUDE * v + (64'd1 << 29)) >> 30;
      if (r > AMPLITUDE) r = AMPLITUDE;
      return r[15:0];
   endfunction

   function automatic sample_type tone_sample(input logic [31:0] phase, input logic is_last);
      logic [9:0]      addr;
      longint unsigned x;
      logic [15:0]     c;
      logic [15:0]     s;
      sample_type      r;
      addr = phase[31:22];
      x = ({56'd0, addr[7:0]} * HALF_PI) >> 8;
      c = amp_round(cosine_poly(x));
      s = amp_round(sine_poly(x));
      case (addr[9:8])
         2'd0: begin r.in_phase = c;  r.quadrature = s;  end
         2'd1: begin r.in_phase = -s; r.quadrature = c;  end
         2'd2: begin r.in_phase = -c; r.quadrature = -s; end
         default: begin r.in_phase = s; r.quadrature = -c; end
      endcase
      r.last = is_last;
      return r;
   endfunction

   function automatic int tone_count();
      int lg;
      lg = int'(tone_order);
      if (lg < 1) lg = 1;
      if (lg > MAX_ORDER) lg = MAX_ORDER;
      return 1 << lg;
   endfunction

   task automatic predict_burst(input logic [5:0] symbol);
      longint unsigned m;
      longint unsigned idx;
      longint unsigned step;
      longint unsigned word64;
      logic [31:0]     freq_word;
      logic [31:0]     phase;
      int              len;
      m = 64'(tone_count());
      len = int'(burst_len);
      if (len < 1) len = 1;
      if (len > MAX_BURST) len = MAX_BURST;
      idx = 64'(symbol);
      if (idx > m - 1) idx = m - 1;
      step = 64'(tone_step);
      word64 = step * (2 * idx + 1) - step * m;
      freq_word = word64[31:0];
      for (int i = 0; i < len; i++) begin
         phase = tone_counter * freq_word;
         samples_due.push_back(tone_sample(phase, i == len - 1));
         tone_counter = tone_counter + 32'd1;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) predict_burst(req.symbol_index);
   end

   always @(posedge clock) begin : check_samples
      sample_type due;
      if (!reset && rsp.valid && rsp.ready) begin
         if (samples_due.size() == 0) begin
            $error("unexpected sample: in_phase %0d quadrature %0d last %0b",
                   $signed(rsp.in_phase), $signed(rsp.quadrature), rsp.last);
            failures++;
         end else begin
            due = samples_due.pop_front();
            if (rsp.in_phase !== due.in_phase) begin
               $error("in_phase: expected %0d, got %0d", $signed(due.in_phase),
                      $signed(rsp.in_phase));
               failures++;
            end
            if (rsp.quadrature !== due.quadrature) begin
               $error("quadrature: expected %0d, got %0d", $signed(due.quadrature),
                      $signed(rsp.quadrature));
               failures++;
            end
            if (rsp.last !== due.last) begin
               $error("last: expected %0b, got %0b", due.last, rsp.last);
               failures++;
            end
         end
      end
   end

   always @(negedge clock) rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_symbol(input logic [5:0] symbol);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req.valid <= 1'b0;
      end
      @(negedge clock);
      req.valid <= 1'b1;
      req.symbol_index <= symbol;
      do @(posedge clock); while (!(req.valid && req.ready));
   endtask

   // drops the request line and waits for every predicted sample
   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (samples_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mfsk_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         mfsk_pkg::CSR_ORDER_LOG2: tone_order = data[2:0];
         mfsk_pkg::CSR_SPS:        burst_len = data[6:0];
         mfsk_pkg::CSR_FREQ_STEP:  tone_step = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [2:0] order, input logic [6:0] len,
                            input logic [31:0] step);
      drain();
      write_reg(mfsk_pkg::CSR_ORDER_LOG2, {29'd0, order});
      write_reg(mfsk_pkg::CSR_SPS, {25'd0, len});
      write_reg(mfsk_pkg::CSR_FREQ_STEP, step);
   endtask

   task automatic test_reset_defaults();
      send_symbol(6'd0);
      send_symbol(6'd1);
      send_symbol(6'd63);
   endtask

   task automatic test_order_range();
      configure(3'd0, 7'd4, 32'h1234_5678);
      send_symbol(6'd0);
      send_symbol(6'd63);
      configure(3'd6, 7'd4, 32'h0800_0000);
      send_symbol(6'd0);
      send_symbol(6'd63);
      configure(3'd7, 7'd3, 32'h0321_0FED);
      send_symbol(6'd5);
      send_symbol(6'd63);
   endtask

   task automatic test_step_extremes();
      configure(3'd2, 7'd5, 32'h0000_0000);
      send_symbol(6'd1);
      configure(3'd3, 7'd5, 32'hFFFF_FFFF);
      send_symbol(6'd2);
      send_symbol(6'd0);
   endtask

   task automatic test_burst_lengths();
      configure(3'd4, 7'd0, 32'h0456_789A);
      send_symbol(6'd7);
      configure(3'd4, 7'd1, 32'h0456_789A);
      send_symbol(6'd9);
      configure(3'd5, 7'd64, 32'h00F0_0F00);
      send_symbol(6'd20);
      configure(3'd5, 7'd65, 32'h00F0_0F00);
      send_symbol(6'd31);
      configure(3'd1, 7'd127, 32'hA5A5_5A5A);
      send_symbol(6'd1);
   endtask

   task automatic test_unused_register();
      drain();
      write_reg(CSR_UNUSED, $urandom());
      send_symbol(6'd3);
   endtask

   task automatic test_drain_and_resume();
      configure(3'd3, 7'd6, $urandom());
      repeat (5) send_symbol(6'($urandom_range(0, 63)));
      drain();
      repeat (5) send_symbol(6'($urandom_range(0, 63)));
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      int sent;
      int batch;
      logic [6:0]  len;
      logic [31:0] step;
      drain();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 85) len = 7'($urandom_range(0, 16));
         else len = 7'($urandom_range(17, 127));
         case ($urandom_range(9))
            0: step = 32'h0000_0000;
            1: step = 32'hFFFF_FFFF;
            default: step = $urandom();
         endcase
         configure(3'($urandom_range(0, 7)), len, step);
         batch = $urandom_range(6, 20);
         if (batch > count - sent) batch = count - sent;
         for (int i = 0; i < batch; i++) begin
            if ($urandom_range(99) < 75) send_symbol(6'($urandom_range(0, tone_count() - 1)));
            else send_symbol(6'($urandom_range(0, 63)));
         end
         sent += batch;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.symbol_index = '0;
      rsp.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_order_range();
      test_step_extremes();
      test_burst_lengths();
      test_unused_register();
      test_drain_and_resume();
      test_random_traffic(0, 0, 85);
      test_random_traffic(82, 0, 85);
      test_random_traffic(0, 82, 85);
      test_random_traffic(37, 37, 85);

      drain();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mfsk_pkg.sv
rtl/mfsk_if.sv
rtl/mfsk_csr.sv
rtl/mfsk_ctrl.sv
rtl/mfsk_dp.sv
rtl/mfsk_tone_generator.sv
tb/tb_mfsk_tone_generator.sv
